/* hdl/ir_climate_frame_encoder_macros.svh */
// Assertion helpers for the encoder RTL.
`ifndef IR_CLIMATE_FRAME_ENCODER_MACROS_SVH
`define IR_CLIMATE_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, silent while rst_ni is low.
`define ICFE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, silent while rst_ni is low.
`define ICFE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/icfe_pkg.sv */
package icfe_pkg;

  localparam int unsigned FrameBitsDef = 43;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned InDataW      = 16;

  localparam logic [63:0] WordPrefix = 64'h0000_0251_5000_0000;
  localparam int unsigned OnBitPos   = 3;
  localparam int unsigned TempPos    = 8;
  localparam logic [3:0]  OffsetMax  = 4'd15;
  localparam logic [10:0] HalfQ4     = 11'h008;

  // Input mode selector.
  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_CHILL    = 3'd1,
    MODE_WARM     = 3'd2,
    MODE_DUAL     = 3'd3,
    MODE_DEHUMID  = 3'd4,
    MODE_FAN_ONLY = 3'd5
  } mode_e;

  // Mode codes as they appear in the frame word.
  localparam logic [2:0] CodeCool     = 3'h1;
  localparam logic [2:0] CodeHeat     = 3'h4;
  localparam logic [2:0] CodeHeatCool = 3'h0;
  localparam logic [2:0] CodeDry      = 3'h2;
  localparam logic [2:0] CodeFanOnly  = 3'h3;

  typedef enum logic [2:0] {
    FAN_SPEED_AUTO = 3'd0,
    FAN_LOW        = 3'd1,
    FAN_MEDIUM     = 3'd2,
    FAN_MIDDLE     = 3'd3,
    FAN_HIGH       = 3'd4
  } fan_e;

  localparam logic [7:0] FanCodeAuto   = 8'h80;
  localparam logic [7:0] FanCodeLow    = 8'h10;
  localparam logic [7:0] FanCodeMedium = 8'h20;
  localparam logic [7:0] FanCodeMiddle = 8'h30;
  localparam logic [7:0] FanCodeHigh   = 8'h40;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER_MARK  = 3'd0,
    REG_HEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ONE_SPACE    = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_TEMP_MIN     = 3'd5,
    REG_TEMP_MAX     = 3'd6
  } cfg_reg_e;

  localparam logic [15:0] HeaderMarkRst  = 16'd9000;
  localparam logic [15:0] HeaderSpaceRst = 16'd4500;
  localparam logic [15:0] BitMarkRst     = 16'd650;
  localparam logic [15:0] OneSpaceRst    = 16'd1650;
  localparam logic [15:0] ZeroSpaceRst   = 16'd550;
  localparam logic [5:0]  TempMinRst     = 6'd16;
  localparam logic [5:0]  TempMaxRst     = 6'd30;

  typedef struct packed {
    logic [15:0] header_mark;
    logic [15:0] header_space;
    logic [15:0] bit_mark;
    logic [15:0] one_space;
    logic [15:0] zero_space;
  } pulse_cfg_t;

  typedef struct packed {
    logic [5:0] min_deg;
    logic [5:0] max_deg;
  } temp_cfg_t;

endpackage

/* hdl/ir_climate_frame_encoder.sv */
// Path: an accepted setting is written into the queue on the slave side, and its header pulse
// item then reaches the master side through the output register of the back end.
// Throughput: one pulse item per cycle while tready is high and a setting is waiting;
// a frame ends before the next starts, and a two-entry queue lets settings arrive early.
// Reset: timing and temperature registers return to their defaults, the stored mode code
// clears to zero, the queue empties and the output holds no transaction.
module ir_climate_frame_encoder #(
  parameter int unsigned FRAME_BITS = icfe_pkg::FrameBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Setting transactions.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: mode [2:0], target_temp_q4 [12:3], fan_speed [15:13]
  input  logic [icfe_pkg::InDataW-1:0] s_axis_tdata,
  // Pulse item transactions.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: mark_us [15:0], space_us [31:16], frame_word [FRAME_BITS+31:32], zero fill
  output logic [((32 + FRAME_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                        m_axis_tlast,
  // Configuration writes.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [icfe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [icfe_pkg::CfgDataW-1:0] cfg_data_i
);
  import icfe_pkg::*;

  `include "ir_climate_frame_encoder_macros.svh"

  localparam int unsigned OutW = ((32 + FRAME_BITS + 7) / 8) * 8;

  // Configuration registers. Writes are always taken; an index past the
  // register list is dropped, and temperatures keep only their low six bits.
  pulse_cfg_t pulse_cfg_q, pulse_cfg_d;
  temp_cfg_t  temp_cfg_q, temp_cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    pulse_cfg_d = pulse_cfg_q;
    temp_cfg_d  = temp_cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HEADER_MARK:  pulse_cfg_d.header_mark  = cfg_data_i;
        REG_HEADER_SPACE: pulse_cfg_d.header_space = cfg_data_i;
        REG_BIT_MARK:     pulse_cfg_d.bit_mark     = cfg_data_i;
        REG_ONE_SPACE:    pulse_cfg_d.one_space    = cfg_data_i;
        REG_ZERO_SPACE:   pulse_cfg_d.zero_space   = cfg_data_i;
        REG_TEMP_MIN:     temp_cfg_d.min_deg       = cfg_data_i[5:0];
        REG_TEMP_MAX:     temp_cfg_d.max_deg       = cfg_data_i[5:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_cfg_q.header_mark  <= HeaderMarkRst;
      pulse_cfg_q.header_space <= HeaderSpaceRst;
      pulse_cfg_q.bit_mark     <= BitMarkRst;
      pulse_cfg_q.one_space    <= OneSpaceRst;
      pulse_cfg_q.zero_space   <= ZeroSpaceRst;
      temp_cfg_q.min_deg       <= TempMinRst;
      temp_cfg_q.max_deg       <= TempMaxRst;
    end else begin
      pulse_cfg_q <= pulse_cfg_d;
      temp_cfg_q  <= temp_cfg_d;
    end
  end

  // The front end builds the code word in the cycle a setting is accepted
  // and tracks the last mode that switched the unit on.
  logic                  q_full, q_push, q_valid, q_pop;
  logic [FRAME_BITS-1:0] q_wdata, q_rdata;

  icfe_front #(
    .FRAME_BITS (FRAME_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .mode_i           (s_axis_tdata[2:0]),
    .target_temp_q4_i (s_axis_tdata[12:3]),
    .fan_speed_i      (s_axis_tdata[15:13]),
    .temp_cfg_i       (temp_cfg_q),
    .q_full_i         (q_full),
    .push_o           (q_push),
    .word_o           (q_wdata)
  );

  // Finished words wait here while the serializer works on an earlier one.
  icfe_queue #(
    .WIDTH (FRAME_BITS),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // The back end sends header, data bits LSB first and the trailing mark.
  logic [15:0]           out_mark, out_space;
  logic [FRAME_BITS-1:0] out_word;
  logic                  out_last;

  icfe_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pulse_cfg_i  (pulse_cfg_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_rdata),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .mark_us_o    (out_mark),
    .space_us_o   (out_space),
    .frame_word_o (out_word),
    .last_o       (out_last)
  );

  assign m_axis_tdata = OutW'({out_word, out_space, out_mark});
  assign m_axis_tlast = out_last;

  // The trailing mark never carries a space.
  `ICFE_ASSERT_IMP(a_last_no_space, m_axis_tvalid && m_axis_tlast, out_space == 16'd0, "final item with nonzero space")
  // Inside a frame the serializer never leaves a gap.
  `ICFE_ASSERT_NXT(a_no_bubble, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside a frame")
  // Every item of a frame carries the same code word.
  `ICFE_ASSERT_NXT(a_word_stable, m_axis_tvalid && m_axis_tready && !m_axis_tlast, out_word == $past(out_word), "code word changed inside a frame")

endmodule

/* hdl/icfe_front.sv */
module icfe_front #(
  parameter int unsigned FRAME_BITS = icfe_pkg::FrameBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            mode_i,
  input  logic [9:0]            target_temp_q4_i,
  input  logic [2:0]            fan_speed_i,
  input  icfe_pkg::temp_cfg_t   temp_cfg_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output logic [FRAME_BITS-1:0] word_o
);
  import icfe_pkg::*;

  logic [2:0]  prev_mode_q, prev_mode_d;
  logic [2:0]  mode_code;
  logic        on_bit;
  logic [7:0]  fan_code;
  logic [9:0]  lo_q4, hi_q4, t_clamp;
  logic [10:0] t_round;
  logic [6:0]  deg, diff;
  logic [3:0]  offset;
  logic [63:0] word_full;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    on_bit    = 1'b1;
    mode_code = prev_mode_q;
    case (mode_i)
      MODE_CHILL:    mode_code = CodeCool;
      MODE_WARM:     mode_code = CodeHeat;
      MODE_DUAL:     mode_code = CodeHeatCool;
      MODE_DEHUMID:  mode_code = CodeDry;
      MODE_FAN_ONLY: mode_code = CodeFanOnly;
      default: begin
        // Off or unknown: resend the stored mode with the unit switched off.
        on_bit    = 1'b0;
        mode_code = prev_mode_q;
      end
    endcase
  end

  always_comb begin
    case (fan_speed_i)
      FAN_HIGH:   fan_code = FanCodeHigh;
      FAN_MIDDLE: fan_code = FanCodeMiddle;
      FAN_MEDIUM: fan_code = FanCodeMedium;
      FAN_LOW:    fan_code = FanCodeLow;
      default:    fan_code = FanCodeAuto;
    endcase
  end

  // Clamp (lower bound first), round half up to whole degrees, then offset.
  always_comb begin
    lo_q4 = {temp_cfg_i.min_deg, 4'b0000};
    hi_q4 = {temp_cfg_i.max_deg, 4'b0000};
    if (target_temp_q4_i < lo_q4) begin
      t_clamp = lo_q4;
    end else if (target_temp_q4_i > hi_q4) begin
      t_clamp = hi_q4;
    end else begin
      t_clamp = target_temp_q4_i;
    end
    t_round = {1'b0, t_clamp} + HalfQ4;
    deg     = t_round[10:4];
    diff    = deg - {1'b0, temp_cfg_i.min_deg};
    if (deg < {1'b0, temp_cfg_i.min_deg}) begin
      offset = 4'd0;
    end else if (diff > {3'b000, OffsetMax}) begin
      offset = OffsetMax;
    end else begin
      offset = diff[3:0];
    end
  end

  always_comb begin
    word_full = WordPrefix
              | (64'(offset) << TempPos)
              | 64'(fan_code)
              | (64'(on_bit) << OnBitPos)
              | 64'(mode_code);
    word_o = word_full[FRAME_BITS-1:0];
  end

  assign prev_mode_d = push_o ? mode_code : prev_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mode_q <= 3'd0;
    end else begin
      prev_mode_q <= prev_mode_d;
    end
  end

endmodule

/* hdl/icfe_queue.sv */
module icfe_queue #(
  parameter int unsigned WIDTH = icfe_pkg::FrameBitsDef,
  parameter int unsigned DEPTH = icfe_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hdl/icfe_back.sv */
module icfe_back #(
  parameter int unsigned FRAME_BITS = icfe_pkg::FrameBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  icfe_pkg::pulse_cfg_t  pulse_cfg_i,
  input  logic                  q_valid_i,
  input  logic [FRAME_BITS-1:0] q_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [15:0]           mark_us_o,
  output logic [15:0]           space_us_o,
  output logic [FRAME_BITS-1:0] frame_word_o,
  output logic                  last_o
);
  import icfe_pkg::*;

  localparam int unsigned CntW = $clog2(FRAME_BITS + 1);

  logic                  busy_q, busy_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [FRAME_BITS-1:0] sh_q;
  logic [15:0]           mark_q, space_q;
  logic [FRAME_BITS-1:0] word_q;
  logic                  last_q;
  logic                  out_free, start, step, final_item;

  assign out_free   = !out_valid_q || out_ready_i;
  assign start      = !busy_q && q_valid_i && out_free;
  assign step       = busy_q && out_free;
  assign final_item = (cnt_q == CntW'(FRAME_BITS));
  assign pop_o      = start;

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = start || step;
    end
    if (start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (step) begin
      if (final_item) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Data bits leave from the low end of sh_q, least significant first.
  always_ff @(posedge clk_i) begin
    if (start) begin
      mark_q  <= pulse_cfg_i.header_mark;
      space_q <= pulse_cfg_i.header_space;
      word_q  <= q_data_i;
      sh_q    <= q_data_i;
      last_q  <= 1'b0;
    end else if (step) begin
      mark_q <= pulse_cfg_i.bit_mark;
      if (final_item) begin
        space_q <= 16'd0;
        last_q  <= 1'b1;
      end else begin
        space_q <= sh_q[0] ? pulse_cfg_i.one_space : pulse_cfg_i.zero_space;
        sh_q    <= sh_q >> 1;
        last_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mark_us_o    = mark_q;
  assign space_us_o   = space_q;
  assign frame_word_o = word_q;
  assign last_o       = last_q;

endmodule

/* dv/icfe_tb_pkg.sv */
`timescale 1ns / 100ps

package icfe_tb_pkg;

  import icfe_pkg::*;

  localparam int unsigned FrameBits      = FrameBitsDef;
  localparam int unsigned PulseDataW     = ((32 + FrameBits + 7) / 8) * 8;
  localparam int unsigned PulsesPerFrame = FrameBits + 2;

  // One pulse item as the encoder should emit it.
  typedef struct packed {
    logic [15:0]          mark;
    logic [15:0]          space;
    logic [FrameBits-1:0] word;
    logic                 last;
  } pulse_t;

  class ir_frame_scoreboard;

    pulse_cfg_t  timing;
    temp_cfg_t   temps;
    logic [2:0]  stored_mode;
    pulse_t      expected_pulses[$];
    int unsigned errors;
    int unsigned pulses_checked;
    int unsigned settings_noted;

    function new();
      timing = '{header_mark: HeaderMarkRst, header_space: HeaderSpaceRst,
                 bit_mark: BitMarkRst, one_space: OneSpaceRst, zero_space: ZeroSpaceRst};
      temps = '{min_deg: TempMinRst, max_deg: TempMaxRst};
      stored_mode = '0;
      errors = 0;
      pulses_checked = 0;
      settings_noted = 0;
    endfunction

    // Register writes keep only the low bits of each register's width.
    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_HEADER_MARK:  timing.header_mark = data;
        REG_HEADER_SPACE: timing.header_space = data;
        REG_BIT_MARK:     timing.bit_mark = data;
        REG_ONE_SPACE:    timing.one_space = data;
        REG_ZERO_SPACE:   timing.zero_space = data;
        REG_TEMP_MIN:     temps.min_deg = data[5:0];
        REG_TEMP_MAX:     temps.max_deg = data[5:0];
        default: ;
      endcase
    endfunction

    // Builds the remote code word for one setting and updates the stored mode.
    function logic [FrameBits-1:0] encode_setting(logic [2:0] mode, logic [9:0] temp_q4,
                                                  logic [2:0] fan);
      logic [63:0] word;
      logic [2:0]  code;
      logic        on;
      logic [7:0]  fan_code;
      int unsigned t, lo, hi, deg, offset;
      word = WordPrefix;
      on = 1'b1;
      case (mode)
        MODE_CHILL:    code = CodeCool;
        MODE_WARM:     code = CodeHeat;
        MODE_DUAL:     code = CodeHeatCool;
        MODE_DEHUMID:  code = CodeDry;
        MODE_FAN_ONLY: code = CodeFanOnly;
        default: begin
          // Off and the unused selectors resend the last mode with the on bit clear.
          code = stored_mode;
          on = 1'b0;
        end
      endcase
      stored_mode = code;

      lo = 16 * int'(temps.min_deg);
      hi = 16 * int'(temps.max_deg);
      t = temp_q4;
      if (t < lo) begin
        t = lo;
      end else if (t > hi) begin
        t = hi;
      end
      deg = (t + int'(HalfQ4)) >> 4;
      offset = (deg < temps.min_deg) ? 0 : deg - temps.min_deg;
      if (offset > OffsetMax) begin
        offset = OffsetMax;
      end

      case (fan)
        FAN_HIGH:   fan_code = FanCodeHigh;
        FAN_MIDDLE: fan_code = FanCodeMiddle;
        FAN_MEDIUM: fan_code = FanCodeMedium;
        FAN_LOW:    fan_code = FanCodeLow;
        default:    fan_code = FanCodeAuto;
      endcase

      word[2:0] = code;
      word[OnBitPos] = on;
      word[TempPos +: 4] = offset[3:0];
      word[7:0] = word[7:0] | fan_code;
      return word[FrameBits-1:0];
    endfunction

    // An accepted setting queues its whole pulse train.
    function void note_setting(logic [InDataW-1:0] data);
      logic [FrameBits-1:0] word;
      word = encode_setting(data[2:0], data[12:3], data[15:13]);
      expected_pulses.push_back('{timing.header_mark, timing.header_space, word, 1'b0});
      for (int b = 0; b < FrameBits; b++) begin
        expected_pulses.push_back('{timing.bit_mark,
                                    word[b] ? timing.one_space : timing.zero_space,
                                    word, 1'b0});
      end
      expected_pulses.push_back('{timing.bit_mark, 16'd0, word, 1'b1});
      settings_noted++;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $error("pulse %0d field %s: expected %0h, actual %0h", pulses_checked, name, want, got);
      end
    endfunction

    function void check_pulse(logic [PulseDataW-1:0] data, logic last);
      pulse_t want;
      pulses_checked++;
      if (expected_pulses.size() == 0) begin
        errors++;
        $error("pulse %0d arrived with no setting behind it: tdata %0h", pulses_checked, data);
        return;
      end
      want = expected_pulses.pop_front();
      compare_field("mark_us", 64'(want.mark), 64'(data[15:0]));
      compare_field("space_us", 64'(want.space), 64'(data[31:16]));
      compare_field("frame_word", 64'(want.word), 64'(data[32 +: FrameBits]));
      compare_field("zero_fill", 64'd0, 64'(data >> (32 + FrameBits)));
      compare_field("last", 64'(want.last), 64'(last));
    endfunction

    function int unsigned pending();
      return expected_pulses.size();
    endfunction

  endclass

endpackage

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  import icfe_pkg::*;
  import icfe_tb_pkg::*;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned ResetCycles = 12;
  // Quiet time after the last pulse item lets the block settle before
  // registers are touched.
  localparam int unsigned DrainCycles = 8;
  // The receiver stops taking pulse items once, part way into the second
  // register setup, and holds off long enough for the input queue to fill.
  localparam int unsigned PressureAt   = PulsesPerFrame * 14 + 7;
  localparam int unsigned PressureHold = 300;
  // The register index that decodes to nothing; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataW-1:0]     s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [PulseDataW-1:0]  m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i = '0;
  logic [CfgDataW-1:0]    cfg_data_i = '0;

  // Random idling on both sides; cleared for the closing part of the run.
  bit                     idle_en = 1'b1;
  int unsigned            setups_loaded = 0;

  ir_frame_scoreboard     sb = new();

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  ir_climate_frame_encoder #(
    .FRAME_BITS(FrameBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Offers one setting and returns at the edge where the transaction is
  // accepted. Valid stays high into the next call unless a gap is drawn, so
  // back-to-back settings never drop valid for a single step.
  task automatic send_setting(input logic [2:0] mode, input logic [9:0] temp_q4,
                              input logic [2:0] fan);
    logic [InDataW-1:0] data;
    data = {fan, temp_q4, mode};
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_setting(data);
  endtask

  // Temperatures mostly fall around the clamp window, so rounding and both
  // bounds get hit often; a quarter span the whole 10-bit range.
  function automatic logic [9:0] pick_temp();
    int lo, hi, base, top;
    lo = 16 * int'(sb.temps.min_deg);
    hi = 16 * int'(sb.temps.max_deg);
    base = ((lo < hi) ? lo : hi) - 24;
    top = ((lo > hi) ? lo : hi) + 24;
    if (base < 0) begin
      base = 0;
    end
    if (top > 1023) begin
      top = 1023;
    end
    if ($urandom_range(0, 3) == 0) begin
      return 10'($urandom_range(0, 1023));
    end
    return 10'($urandom_range(base, top));
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) begin
      send_setting(3'($urandom_range(0, 7)), pick_temp(), 3'($urandom_range(0, 7)));
    end
  endtask

  // Drops valid, waits for every queued pulse item, then lets the block settle.
  task automatic drain_frames();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, val);
  endtask

  // Writes all seven registers, then a junk write to the unused index that the
  // block must ignore. Only called while the block is idle.
  task automatic program_registers(input logic [15:0] hdr_mark, input logic [15:0] hdr_space,
                                   input logic [15:0] bit_mark, input logic [15:0] one_space,
                                   input logic [15:0] zero_space, input logic [15:0] min_deg,
                                   input logic [15:0] max_deg);
    write_reg(REG_HEADER_MARK, hdr_mark);
    write_reg(REG_HEADER_SPACE, hdr_space);
    write_reg(REG_BIT_MARK, bit_mark);
    write_reg(REG_ONE_SPACE, one_space);
    write_reg(REG_ZERO_SPACE, zero_space);
    write_reg(REG_TEMP_MIN, min_deg);
    write_reg(REG_TEMP_MAX, max_deg);
    write_reg(RegUnused, 16'($urandom));
    cfg_valid_i <= 1'b0;
    setups_loaded++;
  endtask

  // Pulse item receiver: checks every accepted transaction and decides the
  // next cycle's ready. Short random stalls while idling is enabled, and one
  // long hold-off counted here to back the block up into its input.
  initial begin : pulse_sink
    int unsigned stall_left;
    int unsigned hold_left;
    bit          pressure_done;
    stall_left = 0;
    hold_left = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_pulse(m_axis_tdata, m_axis_tlast);
      end
      if (!pressure_done && sb.pulses_checked == PressureAt) begin
        hold_left = PressureHold;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned tmin;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Reset values. Off comes first so the cleared stored mode code is sent,
    // then every mode and fan selector, both temperature bounds, rounding on
    // either side of a half degree and the unused selectors.
    send_setting(MODE_OFF, 10'd0, FAN_SPEED_AUTO);
    send_setting(MODE_CHILL, 10'd1023, FAN_HIGH);
    send_setting(MODE_WARM, 10'd327, FAN_LOW);
    send_setting(MODE_DUAL, 10'd328, FAN_MEDIUM);
    send_setting(MODE_DEHUMID, 10'd256, FAN_MIDDLE);
    send_setting(MODE_FAN_ONLY, 10'd480, 3'd5);
    send_setting(3'd6, 10'd300, 3'd6);
    send_setting(3'd7, 10'd400, 3'd7);
    send_setting(MODE_OFF, 10'd479, FAN_HIGH);
    send_setting(MODE_CHILL, 10'd255, FAN_SPEED_AUTO);
    drain_frames();

    // Timing extremes and the widest window: offsets above 15 must saturate
    // without spilling past the temperature field. The long receiver hold lands here.
    program_registers(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd63);
    send_setting(MODE_CHILL, 10'd1023, FAN_HIGH);
    send_setting(MODE_DEHUMID, 10'd248, FAN_LOW);
    send_setting(MODE_WARM, 10'd232, FAN_MEDIUM);
    send_setting(MODE_OFF, 10'd0, FAN_SPEED_AUTO);
    send_setting(MODE_FAN_ONLY, 10'd7, FAN_MIDDLE);
    send_random(40);
    drain_frames();

    // Opposite timing extremes, and a minimum above the maximum, written with
    // junk in the upper data bits that the 6-bit registers must drop.
    program_registers(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFE8, 16'hC014);
    send_setting(MODE_CHILL, 10'd0, FAN_HIGH);
    send_setting(MODE_WARM, 10'd1023, FAN_LOW);
    send_setting(3'd6, 10'd500, 3'd7);
    send_setting(MODE_DUAL, 10'd640, FAN_MEDIUM);
    send_random(30);
    drain_frames();

    // Random timing and a random, mostly sensible, temperature window.
    tmin = $urandom_range(0, 45);
    program_registers(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), {10'($urandom), 6'(tmin)},
                      {10'($urandom), 6'(tmin + $urandom_range(0, 18))});
    send_random(60);
    drain_frames();

    // Closing part at full rate with the reset values back in place.
    idle_en = 1'b0;
    program_registers(HeaderMarkRst, HeaderSpaceRst, BitMarkRst, OneSpaceRst, ZeroSpaceRst,
                      16'(TempMinRst), 16'(TempMaxRst));
    send_random(60);
    drain_frames();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d settings over %0d register setups, %0d pulse items checked.",
             sb.settings_noted, setups_loaded, sb.pulses_checked);
    $display("Mismatches found: %0d.", sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Safety net: a hung handshake ends the run as a failure.
  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d pulse items still expected.", sb.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule
